FILE: rtl/core/bavsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_pkg
// Shared constants, register codes and types for the block average silence
// gate.
// ----------------------------------------------------------------------------
package bavsg_pkg;

    localparam int BLOCK_MAX_DEF        = 4096;
    localparam int CHUNK_COUNT_BITS_DEF = 40;
    localparam int QUEUE_DEPTH          = 2;

    localparam int SAMPLE_W    = 32;
    localparam int THRESH_W    = 31;
    localparam int BFRAMES_W   = 13;
    localparam int DIVISOR_W   = 18;
    localparam int CHUNK_W     = 40;
    localparam int AVG_W       = 32;
    localparam int VERDICT_W   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [THRESH_W-1:0]  THRESHOLD_RST = 31'd30;
    localparam logic [BFRAMES_W-1:0] BFRAMES_RST   = 13'd1024;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST   = 18'd44100;
    localparam logic [CHUNK_W-1:0]   MIN_CHUNK_RST = 40'd44100;
    localparam logic [CHUNK_W-1:0]   MAX_CHUNK_RST = 40'd441000;

    // verdict bit positions
    localparam int VERDICT_SHORT = 0;
    localparam int VERDICT_LONG  = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD    = 3'd0,
        CFG_BLOCK_FRAMES = 3'd1,
        CFG_DIVISOR      = 3'd2,
        CFG_MIN_CHUNK    = 3'd3,
        CFG_MAX_CHUNK    = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_EOS    = 1'b1
    } action_t;

    typedef enum logic {
        KIND_BLOCK = 1'b0,
        KIND_CHUNK = 1'b1
    } kind_t;

    typedef struct packed {
        logic [THRESH_W-1:0]  threshold;
        logic [BFRAMES_W-1:0] block_frames;
        logic [DIVISOR_W-1:0] sample_divisor;
        logic [CHUNK_W-1:0]   min_chunk_frames;
        logic [CHUNK_W-1:0]   max_chunk_frames;
    } cfg_t;

    // command passed from front to back
    typedef struct packed {
        logic decide;
        logic eos;
    } cmd_flags_t;

endpackage
`default_nettype wire

FILE: rtl/core/bavsg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient holds
// after done until the next start.
// ----------------------------------------------------------------------------
module bavsg_div #(
    parameter int DW = 32,
    parameter int VW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(DW);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DW-2:0], ge};
            rem_next  = ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bavsg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_front
// Accepts items, scales each sample by the divisor, gathers the block sum and
// frame count, and queues a decision or end-of-stream order for the back end.
// ----------------------------------------------------------------------------
module bavsg_front #(
    parameter int BLOCK_MAX = bavsg_pkg::BLOCK_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bavsg_pkg::cfg_t                     cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [bavsg_pkg::SAMPLE_W-1:0] sample,
    output logic                                q_push,
    input  logic                                q_full,
    output bavsg_pkg::cmd_flags_t               q_flags,
    output logic [32+$clog2(BLOCK_MAX)-1:0]     q_sum,
    output logic [$clog2(BLOCK_MAX+1)-1:0]      q_frames
);
    import bavsg_pkg::*;

    localparam int FRAME_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W   = 32 + $clog2(BLOCK_MAX);
    localparam int LEN_W   = (BFRAMES_W > FRAME_W) ? BFRAMES_W : FRAME_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [FRAME_W-1:0]   frames_reg, frames_next;
    cmd_flags_t           cmd_flags_reg, cmd_flags_next;
    logic [SUM_W-1:0]     cmd_sum_reg, cmd_sum_next;
    logic [FRAME_W-1:0]   cmd_frames_reg, cmd_frames_next;

    logic                 accept;
    logic [SAMPLE_W-1:0]  s_u;
    logic [SAMPLE_W-1:0]  mag;
    logic [DIVISOR_W-1:0] dvs;
    logic                 div_start;
    logic                 div_done;
    logic [SAMPLE_W-1:0]  quotient;
    logic [LEN_W-1:0]     blk;
    logic [LEN_W-1:0]     len;
    logic [SUM_W-1:0]     new_sum;
    logic [FRAME_W-1:0]   new_frames;
    logic                 full;

    assign in_ready  = (state_reg == F_IDLE);
    assign accept    = in_valid && in_ready;
    assign s_u       = $unsigned(sample);
    assign mag       = s_u[SAMPLE_W-1] ? (~s_u + SAMPLE_W'(1)) : s_u;
    assign dvs       = (cfg.sample_divisor == '0) ? DIVISOR_W'(1) : cfg.sample_divisor;
    assign div_start = accept && (action_t'(action) == ACT_SAMPLE);

    bavsg_div #(
        .DW (SAMPLE_W),
        .VW (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quotient)
    );

    // zero length acts as one frame, oversize clamps to the block maximum
    always_comb
    begin
        blk = LEN_W'(cfg.block_frames);
        if (blk == '0)
        begin
            len = LEN_W'(1);
        end
        else if (blk > LEN_W'(BLOCK_MAX))
        begin
            len = LEN_W'(BLOCK_MAX);
        end
        else
        begin
            len = blk;
        end
    end

    assign new_sum    = sum_reg + SUM_W'(quotient);
    assign new_frames = frames_reg + FRAME_W'(1);
    assign full       = (LEN_W'(new_frames) >= len);

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        frames_next     = frames_reg;
        cmd_flags_next  = cmd_flags_reg;
        cmd_sum_next    = cmd_sum_reg;
        cmd_frames_next = cmd_frames_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (action_t'(action) == ACT_EOS)
                    begin
                        cmd_flags_next.decide = (frames_reg != '0);
                        cmd_flags_next.eos    = 1'b1;
                        cmd_sum_next          = sum_reg;
                        cmd_frames_next       = frames_reg;
                        sum_next              = '0;
                        frames_next           = '0;
                        state_next            = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    if (full)
                    begin
                        cmd_flags_next.decide = 1'b1;
                        cmd_flags_next.eos    = 1'b0;
                        cmd_sum_next          = new_sum;
                        cmd_frames_next       = new_frames;
                        sum_next              = '0;
                        frames_next           = '0;
                        state_next            = F_PUSH;
                    end
                    else
                    begin
                        sum_next    = new_sum;
                        frames_next = new_frames;
                        state_next  = F_IDLE;
                    end
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            sum_reg    <= '0;
            frames_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            frames_reg <= frames_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_flags_reg  <= cmd_flags_next;
        cmd_sum_reg    <= cmd_sum_next;
        cmd_frames_reg <= cmd_frames_next;
    end

    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_flags  = cmd_flags_reg;
    assign q_sum    = cmd_sum_reg;
    assign q_frames = cmd_frames_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bavsg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_fifo
// Short order queue between the front and back ends.
// ----------------------------------------------------------------------------
module bavsg_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = bavsg_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         nonempty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign dout     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bavsg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_back
// Takes queued orders, divides the block sum by its frame count, decides the
// block, tracks the open chunk and drives the result register.
// ----------------------------------------------------------------------------
module bavsg_back #(
    parameter int BLOCK_MAX        = bavsg_pkg::BLOCK_MAX_DEF,
    parameter int CHUNK_COUNT_BITS = bavsg_pkg::CHUNK_COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bavsg_pkg::cfg_t                     cfg,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  bavsg_pkg::cmd_flags_t               q_flags,
    input  logic [32+$clog2(BLOCK_MAX)-1:0]     q_sum,
    input  logic [$clog2(BLOCK_MAX+1)-1:0]      q_frames,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                kind,
    output logic                                block_noisy,
    output logic [bavsg_pkg::AVG_W-1:0]         block_average,
    output logic [bavsg_pkg::BFRAMES_W-1:0]     block_length,
    output logic [bavsg_pkg::CHUNK_W-1:0]       chunk_length,
    output logic [bavsg_pkg::VERDICT_W-1:0]     chunk_verdict,
    output logic                                last
);
    import bavsg_pkg::*;

    localparam int FRAME_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W   = 32 + $clog2(BLOCK_MAX);
    localparam int CW      = CHUNK_COUNT_BITS;
    localparam int ADD_W   = ((CW > FRAME_W) ? CW : FRAME_W) + 1;
    localparam int CMP_W   = (CW > CHUNK_W) ? CW : CHUNK_W;
    localparam logic [CW-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_DIV   = 4'b0010,
        B_BLOCK = 4'b0100,
        B_CLOSE = 4'b1000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic                 eos_reg, eos_next;
    logic [FRAME_W-1:0]   n_reg, n_next;
    logic                 open_reg, open_next;
    logic [CW-1:0]        count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                kind_reg, kind_next;
    logic                 noisy_reg, noisy_next;
    logic [AVG_W-1:0]     avg_reg, avg_next;
    logic [BFRAMES_W-1:0] blen_reg, blen_next;
    logic [CHUNK_W-1:0]   clen_reg, clen_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                 last_reg, last_next;

    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;
    logic [AVG_W-1:0]     avg;
    logic                 noisy;
    logic                 out_free;
    logic [CW-1:0]        base;
    logic [ADD_W-1:0]     add;
    logic [CW-1:0]        sat_count;
    logic [VERDICT_W-1:0] verdict;
    logic                 close_after;

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign div_start = q_pop && q_flags.decide;

    bavsg_div #(
        .DW (SUM_W),
        .VW (FRAME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_sum),
        .divisor  (q_frames),
        .done     (div_done),
        .quotient (quotient)
    );

    assign avg      = quotient[AVG_W-1:0];
    assign noisy    = (avg > {1'b0, cfg.threshold});
    assign out_free = !out_valid_reg || out_ready;

    // a closed chunk restarts from zero; the count saturates at all ones
    assign base      = open_reg ? count_reg : '0;
    assign add       = ADD_W'(base) + ADD_W'(n_reg);
    assign sat_count = (add > ADD_W'(COUNT_MAX)) ? COUNT_MAX : add[CW-1:0];

    always_comb
    begin
        verdict                = '0;
        verdict[VERDICT_SHORT] = (CMP_W'(count_reg) < CMP_W'(cfg.min_chunk_frames));
        verdict[VERDICT_LONG]  = (CMP_W'(count_reg) > CMP_W'(cfg.max_chunk_frames));
    end

    assign close_after = noisy ? eos_reg : open_reg;

    always_comb
    begin
        state_next     = state_reg;
        eos_next       = eos_reg;
        n_next         = n_reg;
        open_next      = open_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        noisy_next     = noisy_reg;
        avg_next       = avg_reg;
        blen_next      = blen_reg;
        clen_next      = clen_reg;
        verdict_next   = verdict_reg;
        last_next      = last_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    eos_next = q_flags.eos;
                    n_next   = q_frames;
                    if (q_flags.decide)
                    begin
                        state_next = B_DIV;
                    end
                    else if (q_flags.eos && open_reg)
                    begin
                        state_next = B_CLOSE;
                    end
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    state_next = B_BLOCK;
                end
            end
            B_BLOCK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BLOCK;
                    noisy_next     = noisy;
                    avg_next       = avg;
                    blen_next      = BFRAMES_W'(n_reg);
                    clen_next      = '0;
                    verdict_next   = '0;
                    last_next      = !close_after;
                    if (noisy)
                    begin
                        open_next  = 1'b1;
                        count_next = sat_count;
                    end
                    state_next = close_after ? B_CLOSE : B_IDLE;
                end
            end
            B_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CHUNK;
                    noisy_next     = 1'b0;
                    avg_next       = '0;
                    blen_next      = '0;
                    clen_next      = CHUNK_W'(count_reg);
                    verdict_next   = verdict;
                    last_next      = 1'b1;
                    open_next      = 1'b0;
                    count_next     = '0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            open_reg      <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eos_reg     <= eos_next;
        n_reg       <= n_next;
        kind_reg    <= kind_next;
        noisy_reg   <= noisy_next;
        avg_reg     <= avg_next;
        blen_reg    <= blen_next;
        clen_reg    <= clen_next;
        verdict_reg <= verdict_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign block_noisy   = noisy_reg;
    assign block_average = avg_reg;
    assign block_length  = blen_reg;
    assign chunk_length  = clen_reg;
    assign chunk_verdict = verdict_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

FILE: rtl/core/block_average_silence_gate.sv
`default_nettype none
// Each sample passes through a 32-step sample divider before the next one is taken;
// a finished block is then queued as an order for the mean divider, which divides its sum.
// The mean divider works on one block at a time, so with block_frames of 1 input is
// paced by the mean divider once the order queue is full.
// Reset (rst_n low, asynchronous): registers to defaults, counters cleared, queue
// emptied, an empty chunk open, no result pending.
// ----------------------------------------------------------------------------
// block_average_silence_gate
// Energy-based silence gate: block means of scaled sample magnitudes open,
// extend and close chunks of noisy audio.
// ----------------------------------------------------------------------------
module block_average_silence_gate #(
    parameter int BLOCK_MAX        = bavsg_pkg::BLOCK_MAX_DEF,
    parameter int CHUNK_COUNT_BITS = bavsg_pkg::CHUNK_COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bavsg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bavsg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic signed [bavsg_pkg::SAMPLE_W-1:0] sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic                                  block_noisy,
    output logic [bavsg_pkg::AVG_W-1:0]           block_average,
    output logic [bavsg_pkg::BFRAMES_W-1:0]       block_length,
    output logic [bavsg_pkg::CHUNK_W-1:0]         chunk_length,
    output logic [bavsg_pkg::VERDICT_W-1:0]       chunk_verdict,
    output logic                                  last
);
    import bavsg_pkg::*;

    localparam int FRAME_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W   = 32 + $clog2(BLOCK_MAX);
    localparam int Q_W     = $bits(cmd_flags_t) + SUM_W + FRAME_W;

    cfg_t               cfg_reg, cfg_next;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_nonempty;
    cmd_flags_t         f_flags, b_flags;
    logic [SUM_W-1:0]   f_sum, b_sum;
    logic [FRAME_W-1:0] f_frames, b_frames;
    logic [Q_W-1:0]     q_din, q_dout;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD:    cfg_next.threshold        = cfg_data[THRESH_W-1:0];
                CFG_BLOCK_FRAMES: cfg_next.block_frames     = cfg_data[BFRAMES_W-1:0];
                CFG_DIVISOR:      cfg_next.sample_divisor   = cfg_data[DIVISOR_W-1:0];
                CFG_MIN_CHUNK:    cfg_next.min_chunk_frames = cfg_data[CHUNK_W-1:0];
                CFG_MAX_CHUNK:    cfg_next.max_chunk_frames = cfg_data[CHUNK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold        <= THRESHOLD_RST;
            cfg_reg.block_frames     <= BFRAMES_RST;
            cfg_reg.sample_divisor   <= DIVISOR_RST;
            cfg_reg.min_chunk_frames <= MIN_CHUNK_RST;
            cfg_reg.max_chunk_frames <= MAX_CHUNK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bavsg_front #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sample   (sample),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_flags  (f_flags),
        .q_sum    (f_sum),
        .q_frames (f_frames)
    );

    assign q_din = {f_flags, f_sum, f_frames};

    bavsg_fifo #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .din      (q_din),
        .full     (q_full),
        .pop      (q_pop),
        .dout     (q_dout),
        .nonempty (q_nonempty)
    );

    assign {b_flags, b_sum, b_frames} = q_dout;

    bavsg_back #(
        .BLOCK_MAX        (BLOCK_MAX),
        .CHUNK_COUNT_BITS (CHUNK_COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_nonempty),
        .q_pop         (q_pop),
        .q_flags       (b_flags),
        .q_sum         (b_sum),
        .q_frames      (b_frames),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .block_noisy   (block_noisy),
        .block_average (block_average),
        .block_length  (block_length),
        .chunk_length  (chunk_length),
        .chunk_verdict (chunk_verdict),
        .last          (last)
    );

endmodule
`default_nettype wire

FILE: rtl/core/bavsg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bavsg_checker
// Port-level checks on the result stream of the silence gate.
// ----------------------------------------------------------------------------
module bavsg_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  out_valid,
    input wire                                  out_ready,
    input wire                                  kind,
    input wire                                  block_noisy,
    input wire [bavsg_pkg::AVG_W-1:0]           block_average,
    input wire [bavsg_pkg::BFRAMES_W-1:0]       block_length,
    input wire [bavsg_pkg::CHUNK_W-1:0]         chunk_length,
    input wire [bavsg_pkg::VERDICT_W-1:0]       chunk_verdict,
    input wire                                  last
);
    import bavsg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({kind, block_noisy,
            block_average, block_length, chunk_length, chunk_verdict, last}))
        else $error("result changed while stalled");

    // a block result that is not last is followed at once by its chunk close
    a_close_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && (kind == KIND_CHUNK))
        else $error("missing chunk close after block decision");

    // chunk close always ends the results of its input
    a_chunk_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CHUNK) |-> last)
        else $error("chunk close not marked last");

    a_chunk_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CHUNK) |->
            !block_noisy && (block_average == '0) && (block_length == '0))
        else $error("block fields set on chunk result");

endmodule

bind block_average_silence_gate bavsg_checker u_bavsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .block_noisy   (block_noisy),
    .block_average (block_average),
    .block_length  (block_length),
    .chunk_length  (chunk_length),
    .chunk_verdict (chunk_verdict),
    .last          (last)
);
`default_nettype wire

FILE: dv/block_average_silence_gate_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_silence_gate_test
// Self-checking testbench for the block average silence gate. A directed
// table covers reset state, field extremes and the corner cases of block
// length, divisor and chunk verdicts. Random phases follow, each with its own
// register setting. Every output transfer is compared field by field against
// an in-bench predictor, with random gaps on input and stalls on output.
// ----------------------------------------------------------------------------
module block_average_silence_gate_test;

    import bavsg_pkg::*;

    localparam int          SETTLE_CYCLES = 120;
    localparam int          TAIL_CYCLES   = 200;
    localparam int          CYCLE_LIMIT   = 4_000_000;
    localparam int          PHASES        = 16;
    localparam int          PHASE_ITEMS   = 40;
    localparam int          BIG_PHASE     = 7;
    localparam int          BIG_FRAMES    = 128;
    localparam logic [63:0] COUNT_LIMIT   = (64'd1 << CHUNK_COUNT_BITS_DEF) - 64'd1;
    localparam logic [CHUNK_W-1:0] ALL_ONES = {CHUNK_W{1'b1}};

    localparam logic [VERDICT_W-1:0] V_KEPT  = '0;
    localparam logic [VERDICT_W-1:0] V_SHORT = VERDICT_W'(1) << VERDICT_SHORT;
    localparam logic [VERDICT_W-1:0] V_LONG  = VERDICT_W'(1) << VERDICT_LONG;
    localparam logic [VERDICT_W-1:0] V_BOTH  = V_SHORT | V_LONG;

    typedef struct packed {
        logic                 kind;
        logic                 noisy;
        logic [AVG_W-1:0]     avg;
        logic [BFRAMES_W-1:0] blen;
        logic [CHUNK_W-1:0]   clen;
        logic [VERDICT_W-1:0] verdict;
        logic                 last;
    } gate_result_t;

    typedef struct {
        bit                    is_cfg;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
        action_t               act;
        logic [SAMPLE_W-1:0]   smp;
        int                    n_typed;  // -1: take the predictor's results
        gate_result_t          t0;
        gate_result_t          t1;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        action = ACT_SAMPLE;
    logic signed [SAMPLE_W-1:0]  sample = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        kind;
    logic                        block_noisy;
    logic [AVG_W-1:0]            block_average;
    logic [BFRAMES_W-1:0]        block_length;
    logic [CHUNK_W-1:0]          chunk_length;
    logic [VERDICT_W-1:0]        chunk_verdict;
    logic                        last;

    block_average_silence_gate u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .block_noisy   (block_noisy),
        .block_average (block_average),
        .block_length  (block_length),
        .chunk_length  (chunk_length),
        .chunk_verdict (chunk_verdict),
        .last          (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [THRESH_W-1:0]  m_threshold    = THRESHOLD_RST;
    logic [BFRAMES_W-1:0] m_block_frames = BFRAMES_RST;
    logic [DIVISOR_W-1:0] m_divisor      = DIVISOR_RST;
    logic [CHUNK_W-1:0]   m_min_chunk    = MIN_CHUNK_RST;
    logic [CHUNK_W-1:0]   m_max_chunk    = MAX_CHUNK_RST;
    int unsigned          m_frames       = 0;
    logic [63:0]          m_sum          = '0;
    bit                   m_open         = 1'b1;
    logic [63:0]          m_chunk        = '0;

    gate_result_t decision_q[$];
    stim_row_t    directed_rows[$];
    int           errors = 0;
    int           cycles = 0;
    bit           no_idle = 1'b0;
    int           ready_hold = 0;
    int           ready_calm = 0;
    int           ready_roll;

    function automatic gate_result_t close_chunk();
        gate_result_t r;
        r = '0;
        r.kind = KIND_CHUNK;
        r.clen = m_chunk[CHUNK_W-1:0];
        r.verdict[VERDICT_SHORT] = m_chunk < m_min_chunk;
        r.verdict[VERDICT_LONG]  = m_chunk > m_max_chunk;
        m_open  = 1'b0;
        m_chunk = '0;
        return r;
    endfunction

    function automatic void gate_step(input action_t act, input logic [SAMPLE_W-1:0] smp,
                                      input bit record);
        gate_result_t r [2];
        int           k;
        bit           decide_now;
        bit           noisy;
        logic [31:0]  mag;
        logic [63:0]  div;
        logic [63:0]  n;
        logic [63:0]  avg;
        int unsigned  len;
        k = 0;
        if (act == ACT_SAMPLE)
        begin
            mag = smp[31] ? (~smp + 32'd1) : smp;
            div = (m_divisor == '0) ? 64'd1 : 64'(m_divisor);
            len = m_block_frames;
            if (len == 0)
                len = 1;
            if (len > BLOCK_MAX_DEF)
                len = BLOCK_MAX_DEF;
            m_sum = m_sum + 64'(mag) / div;
            m_frames++;
            decide_now = m_frames >= len;
        end
        else
            decide_now = m_frames > 0;

        if (decide_now)
        begin
            n     = 64'(m_frames);
            avg   = m_sum / n;
            noisy = avg > 64'(m_threshold);
            r[k]  = '0;
            r[k].kind  = KIND_BLOCK;
            r[k].noisy = noisy;
            r[k].avg   = avg[AVG_W-1:0];
            r[k].blen  = n[BFRAMES_W-1:0];
            k++;
            if (noisy)
            begin
                if (!m_open)
                begin
                    m_open  = 1'b1;
                    m_chunk = '0;
                end
                if (m_chunk > COUNT_LIMIT - n)
                    m_chunk = COUNT_LIMIT;
                else
                    m_chunk = m_chunk + n;
            end
            else if (m_open)
            begin
                r[k] = close_chunk();
                k++;
            end
            m_frames = 0;
            m_sum    = '0;
        end

        if (act == ACT_EOS && m_open)
        begin
            r[k] = close_chunk();
            k++;
        end

        if (k > 0)
            r[k-1].last = 1'b1;
        if (record)
            for (int i = 0; i < k; i++)
                decision_q.push_back(r[i]);
    endfunction

    function automatic gate_result_t blk_res(bit noisy, logic [AVG_W-1:0] avg,
                                             logic [BFRAMES_W-1:0] blen, bit lst);
        gate_result_t r;
        r = '0;
        r.kind  = KIND_BLOCK;
        r.noisy = noisy;
        r.avg   = avg;
        r.blen  = blen;
        r.last  = lst;
        return r;
    endfunction

    function automatic gate_result_t chunk_res(logic [CHUNK_W-1:0] clen,
                                               logic [VERDICT_W-1:0] v, bit lst);
        gate_result_t r;
        r = '0;
        r.kind    = KIND_CHUNK;
        r.clen    = clen;
        r.verdict = v;
        r.last    = lst;
        return r;
    endfunction

    function automatic void row_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.is_cfg  = 1'b1;
        row.idx     = idx;
        row.data    = data;
        row.act     = ACT_SAMPLE;
        row.smp     = '0;
        row.n_typed = -1;
        row.t0      = '0;
        row.t1      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_item(action_t act, logic [SAMPLE_W-1:0] smp, int n_typed,
                                     gate_result_t t0, gate_result_t t1);
        stim_row_t row;
        row.is_cfg  = 1'b0;
        row.idx     = CFG_THRESHOLD;
        row.data    = '0;
        row.act     = act;
        row.smp     = smp;
        row.n_typed = n_typed;
        row.t0      = t0;
        row.t1      = t1;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic drive_item(action_t act, logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // registers change only once the block has gone idle
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (decision_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    m_threshold    = data[THRESH_W-1:0];
            CFG_BLOCK_FRAMES: m_block_frames = data[BFRAMES_W-1:0];
            CFG_DIVISOR:      m_divisor      = data[DIVISOR_W-1:0];
            CFG_MIN_CHUNK:    m_min_chunk    = data[CHUNK_W-1:0];
            CFG_MAX_CHUNK:    m_max_chunk    = data[CHUNK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // output side: short stalls, a few long ones, and calm stretches
    always @(negedge clk)
    begin
        if (ready_calm > 0)
        begin
            ready_calm--;
            out_ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            ready_roll = $urandom_range(0, 999);
            if (ready_roll < 150)
                ready_hold = $urandom_range(1, 3);
            else if (ready_roll < 180)
                ready_hold = $urandom_range(20, 60);
            else if (ready_roll < 183)
                ready_calm = $urandom_range(100, 400);
        end
    end

    always @(posedge clk)
    begin
        gate_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decision_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual kind=%0d avg=%0h clen=%0h",
                         $time, kind, block_average, chunk_length);
                errors++;
            end
            else
            begin
                want = decision_q.pop_front();
                check_field("kind",          64'(want.kind),    64'(kind));
                check_field("block_noisy",   64'(want.noisy),   64'(block_noisy));
                check_field("block_average", 64'(want.avg),     64'(block_average));
                check_field("block_length",  64'(want.blen),    64'(block_length));
                check_field("chunk_length",  64'(want.clen),    64'(chunk_length));
                check_field("chunk_verdict", 64'(want.verdict), 64'(chunk_verdict));
                check_field("last",          64'(want.last),    64'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        action_t          act;
        logic [31:0]      smp;
        logic [31:0]      mag;
        logic [31:0]      div_eff;
        bit               loud;
        int               roll;
        logic [CHUNK_W-1:0] v;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state: the empty chunk closes on end of stream, then nothing pending
        row_item(ACT_EOS, 32'h1234_5678, 1, chunk_res('0, V_SHORT, 1'b1), '0);
        row_item(ACT_EOS, 32'hFFFF_FFFF, 0, '0, '0);
        row_cfg(CFG_BLOCK_FRAMES, 40'd1);
        row_cfg(CFG_DIVISOR, 40'd1);
        row_cfg(CFG_THRESHOLD, 40'd0);
        row_cfg(CFG_MIN_CHUNK, 40'd0);
        row_cfg(CFG_MAX_CHUNK, ALL_ONES);
        // most negative sample, largest average
        row_item(ACT_SAMPLE, 32'h8000_0000, 1, blk_res(1'b1, 32'h8000_0000, 13'd1, 1'b1), '0);
        row_item(ACT_SAMPLE, 32'h0000_0000, 2, blk_res(1'b0, 32'h0, 13'd1, 1'b0),
                 chunk_res(40'd1, V_KEPT, 1'b1));
        row_item(ACT_SAMPLE, 32'h7FFF_FFFF, 1, blk_res(1'b1, 32'h7FFF_FFFF, 13'd1, 1'b1), '0);
        row_cfg(CFG_THRESHOLD, 40'h7FFF_FFFF);
        row_item(ACT_SAMPLE, 32'h8000_0000, 1, blk_res(1'b1, 32'h8000_0000, 13'd1, 1'b1), '0);
        row_item(ACT_SAMPLE, 32'h7FFF_FFFF, 2, blk_res(1'b0, 32'h7FFF_FFFF, 13'd1, 1'b0),
                 chunk_res(40'd2, V_KEPT, 1'b1));
        row_item(ACT_SAMPLE, 32'h0000_0001, 1, blk_res(1'b0, 32'h1, 13'd1, 1'b1), '0);
        // zero divisor acts as one; then a divisor of 192000
        row_cfg(CFG_DIVISOR, 40'd0);
        row_item(ACT_SAMPLE, -32'sd5, -1, '0, '0);
        row_cfg(CFG_DIVISOR, 40'd192000);
        row_item(ACT_SAMPLE, 32'h8000_0000, -1, '0, '0);
        // zero block length acts as one
        row_cfg(CFG_THRESHOLD, 40'd10);
        row_cfg(CFG_DIVISOR, 40'd3);
        row_cfg(CFG_BLOCK_FRAMES, 40'd0);
        row_item(ACT_SAMPLE, 32'd40, -1, '0, '0);
        row_item(ACT_SAMPLE, -32'sd31, -1, '0, '0);
        // block length lowered mid-block
        row_cfg(CFG_BLOCK_FRAMES, 40'd4);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        row_cfg(CFG_BLOCK_FRAMES, 40'd2);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        // oversized block length, partial block flushed by end of stream
        row_cfg(CFG_BLOCK_FRAMES, 40'd8191);
        row_item(ACT_SAMPLE, 32'h7FFF_FFFF, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'hFFFF_FFFF, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'h1234_5678, -1, '0, '0);
        row_item(ACT_EOS, 32'h0, -1, '0, '0);
        // chunk both too short and too long
        row_cfg(CFG_MIN_CHUNK, ALL_ONES);
        row_cfg(CFG_MAX_CHUNK, 40'd0);
        row_cfg(CFG_BLOCK_FRAMES, 40'd2);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'd300, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'd0, -1, '0, '0);
        row_item(ACT_SAMPLE, 32'd0, 2, blk_res(1'b0, 32'd0, 13'd2, 1'b0),
                 chunk_res(40'd2, V_BOTH, 1'b1));
        row_item(ACT_EOS, 32'h0, 0, '0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            else
            begin
                drive_item(directed_rows[i].act, directed_rows[i].smp);
                if (directed_rows[i].n_typed < 0)
                    gate_step(directed_rows[i].act, directed_rows[i].smp, 1'b1);
                else
                begin
                    gate_step(directed_rows[i].act, directed_rows[i].smp, 1'b0);
                    if (directed_rows[i].n_typed > 0)
                        decision_q.push_back(directed_rows[i].t0);
                    if (directed_rows[i].n_typed > 1)
                        decision_q.push_back(directed_rows[i].t1);
                end
            end
        end

        loud = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (ph == BIG_PHASE)
            begin
                // one long block of random samples
                write_reg(CFG_BLOCK_FRAMES, 40'(BIG_FRAMES));
                write_reg(CFG_DIVISOR, 40'd1);
                write_reg(CFG_THRESHOLD, 40'($urandom_range(0, 32'h7FFF_FFFF)));
                write_reg(CFG_MIN_CHUNK, 40'($urandom_range(0, 256)));
                write_reg(CFG_MAX_CHUNK, 40'($urandom_range(0, 256)));
                for (int n = 0; n < BIG_FRAMES; n++)
                begin
                    smp = $urandom();
                    drive_item(ACT_SAMPLE, smp);
                    gate_step(ACT_SAMPLE, smp, 1'b1);
                end
                drive_item(ACT_EOS, $urandom());
                gate_step(ACT_EOS, 32'h0, 1'b1);
                continue;
            end

            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = 40'h7FFF_FFFF;
                default: v = 40'($urandom_range(0, 2000));
            endcase
            write_reg(CFG_THRESHOLD, v);
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = 40'd8191;
                2:       v = 40'($urandom_range(7, 40));
                default: v = 40'($urandom_range(1, 6));
            endcase
            write_reg(CFG_BLOCK_FRAMES, v);
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = 40'd192000;
                2:       v = 40'h3FFFF;
                default: v = 40'($urandom_range(1, 300));
            endcase
            write_reg(CFG_DIVISOR, v);
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = ALL_ONES;
                default: v = 40'($urandom_range(0, 30));
            endcase
            write_reg(CFG_MIN_CHUNK, v);
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = ALL_ONES;
                default: v = 40'($urandom_range(0, 40));
            endcase
            write_reg(CFG_MAX_CHUNK, v);

            div_eff = (m_divisor == '0) ? 32'd1 : 32'(m_divisor);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                act  = ACT_SAMPLE;
                if (roll < 4)
                begin
                    act = ACT_EOS;
                    smp = $urandom();
                end
                else if (roll < 10)
                    smp = $urandom();
                else if (roll == 10)
                    smp = 32'h8000_0000;
                else if (roll == 11)
                    smp = 32'h7FFF_FFFF;
                else
                begin
                    // runs of loud and quiet frames so chunks open and close
                    if ($urandom_range(0, 3) == 0)
                        loud = !loud;
                    if (loud)
                        mag = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                    else
                        mag = $urandom_range(0, div_eff);
                    smp = $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
                end
                drive_item(act, smp);
                gate_step(act, smp, 1'b1);
            end
        end

        in_valid <= 1'b0;
        while (decision_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
